/* sv/otc_pkg.sv */
package otc_pkg;

  // Capture timer width used when the top level is not told otherwise
  localparam int CAPTURE_BITS_DEF = 16;

  // Field widths
  localparam int TRIM_W       = 8;
  localparam int MEAS_W       = 16;
  localparam int TARGET_HZ_W  = 26;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = TARGET_HZ_W;

  // target count = target_hz * 8 / 32768 = target_hz >> 12
  localparam int TARGET_SHIFT = 12;
  localparam int TARGET_W     = TARGET_HZ_W - TARGET_SHIFT;

  // Trim limits
  localparam logic [TRIM_W-1:0] TRIM_MIN = '0;
  localparam logic [TRIM_W-1:0] TRIM_MAX = '1;

  // Command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HZ  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_TRIM = 1'd1;

  // Configuration reset values
  localparam logic [TARGET_HZ_W-1:0] TARGET_HZ_RST  = 26'd2097152;
  localparam logic [TRIM_W-1:0]      START_TRIM_RST = 8'd16;

  // Calibration phases
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST = 2'd1;
  localparam logic [PHASE_W-1:0] PH_NEXT  = 2'd2;

  // One result beat
  typedef struct packed {
    logic [TRIM_W-1:0] trim_out;
    logic [MEAS_W-1:0] measured_count;
    logic              busy_res;
    logic              done_res;
  } res_t;

endpackage

/* sv/otc_in_if.sv */
interface otc_in_if #(
  parameter int CAPTURE_BITS = otc_pkg::CAPTURE_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [CAPTURE_BITS-1:0] capture_value;

  modport source (output valid, output cmd, output capture_value, input ready);
  modport sink   (input valid, input cmd, input capture_value, output ready);
endinterface

/* sv/otc_out_if.sv */
interface otc_out_if;
  import otc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TRIM_W-1:0] trim_out;
  logic [MEAS_W-1:0] measured_count;
  logic              busy_res;
  logic              done_res;

  modport source (output valid, output trim_out, output measured_count,
                  output busy_res, output done_res, input ready);
  modport sink   (input valid, input trim_out, input measured_count,
                  input busy_res, input done_res, output ready);
endinterface

/* sv/otc_cfg_if.sv */
interface otc_cfg_if;
  import otc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/otc_skid.sv */
module otc_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  otc_pkg::res_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output otc_pkg::res_t out_data
);
  import otc_pkg::*;

  logic out_full;
  logic skid_full;
  res_t out_reg;
  res_t skid_reg;
  logic push;
  logic pop;

  assign push      = in_valid & in_ready;
  assign pop       = out_full & out_ready;
  assign in_ready  = ~skid_full;
  assign out_valid = out_full;
  assign out_data  = out_reg;

  // Track occupancy of the output and skid stages
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (pop) begin
        out_full  <= skid_full | push;
        skid_full <= 1'b0;
      end else if (push) begin
        out_full  <= 1'b1;
        skid_full <= out_full;
      end
    end
  end

  // Move payloads: skid drains first, a new beat lands in the free stage
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_full) begin
        out_reg <= skid_reg;
      end else if (push) begin
        out_reg <= in_data;
      end
    end else if (push) begin
      if (out_full) begin
        skid_reg <= in_data;
      end else begin
        out_reg <= in_data;
      end
    end
  end

endmodule

/* sv/oscillator_trim_calibrator_core.sv */
// Oscillator trim calibrator. A start beat (cmd 0) loads start_trim and opens a
// calibration; each following pair of capture beats (cmd 1) measures one count
// as the difference of two timer captures, compares it with target_hz >> 12,
// keeps the best trim and steps the trim one toward the target, saturating at
// 0 and 255. Calibration ends on zero error or when the error stops shrinking,
// and the best trim is applied; that beat carries done_res. Every input beat
// yields exactly one result beat. The block takes one beat per clock while the
// output buffer has room; all work for a beat is done in the accepting cycle
// and the result is registered. A two-entry output buffer lets input continue
// for one more beat while a result waits, stalling only when both entries hold.
module oscillator_trim_calibrator_core #(
  parameter int CAPTURE_BITS = otc_pkg::CAPTURE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  otc_in_if.sink     req,
  otc_out_if.source  rsp,
  otc_cfg_if.sink    cfg
);
  import otc_pkg::*;

  localparam int ERR_W = (CAPTURE_BITS > MEAS_W) ? CAPTURE_BITS : MEAS_W;

  // Configuration registers
  logic [TARGET_HZ_W-1:0] target_hz;
  logic [TRIM_W-1:0]      start_trim;

  // Calibration state
  logic [TRIM_W-1:0]       current_trim, current_trim_next;
  logic [TRIM_W-1:0]       best_trim, best_trim_next;
  logic [ERR_W-1:0]        last_error, last_error_next;
  logic [CAPTURE_BITS-1:0] first_capture, first_capture_next;
  logic                    have_first, have_first_next;
  logic [PHASE_W-1:0]      phase, phase_next;
  logic [MEAS_W-1:0]       last_count, last_count_next;

  logic                    beat;
  logic                    done;
  logic [CAPTURE_BITS-1:0] count;
  logic [ERR_W-1:0]        count_ext;
  logic [ERR_W-1:0]        target_ext;
  logic [ERR_W-1:0]        err;
  logic                    above;
  logic                    improved;
  logic                    buf_ready;
  res_t                    res;
  res_t                    rsp_data;

  assign cfg.ready = 1'b1;
  assign req.ready = buf_ready;
  assign beat      = req.valid & buf_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_hz  <= TARGET_HZ_RST;
      start_trim <= START_TRIM_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TARGET_HZ:  target_hz  <= cfg.data[TARGET_HZ_W-1:0];
        REG_START_TRIM: start_trim <= cfg.data[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Measure: count, target and absolute error
  assign count      = req.capture_value - first_capture;
  assign count_ext  = ERR_W'(count);
  assign target_ext = ERR_W'(target_hz[TARGET_HZ_W-1:TARGET_SHIFT]);
  assign above      = count_ext > target_ext;
  assign err        = above ? (count_ext - target_ext) : (target_ext - count_ext);
  assign improved   = (phase == PH_FIRST) || (last_error > err);

  // Next state for the accepted beat
  always_comb begin
    current_trim_next  = current_trim;
    best_trim_next     = best_trim;
    last_error_next    = last_error;
    first_capture_next = first_capture;
    have_first_next    = have_first;
    phase_next         = phase;
    last_count_next    = last_count;
    done               = 1'b0;
    if (req.cmd == CMD_START) begin
      current_trim_next = start_trim;
      have_first_next   = 1'b0;
      phase_next        = PH_FIRST;
    end else if (phase == PH_IDLE) begin
      // ignore captures while idle
    end else if (!have_first) begin
      first_capture_next = req.capture_value;
      have_first_next    = 1'b1;
    end else begin
      have_first_next = 1'b0;
      last_count_next = count_ext[MEAS_W-1:0];
      if (improved) begin
        best_trim_next = current_trim;
      end
      if (improved && (err != '0)) begin
        last_error_next = err;
        phase_next      = PH_NEXT;
        if (above) begin
          if (current_trim != TRIM_MIN) begin
            current_trim_next = current_trim - 1'b1;
          end
        end else if (current_trim != TRIM_MAX) begin
          current_trim_next = current_trim + 1'b1;
        end
      end else begin
        // finish: apply the best trim seen
        current_trim_next = improved ? current_trim : best_trim;
        phase_next        = PH_IDLE;
        done              = 1'b1;
      end
    end
  end

  // Commit state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      current_trim  <= '0;
      best_trim     <= '0;
      last_error    <= '0;
      first_capture <= '0;
      have_first    <= 1'b0;
      phase         <= PH_IDLE;
      last_count    <= '0;
    end else if (beat) begin
      current_trim  <= current_trim_next;
      best_trim     <= best_trim_next;
      last_error    <= last_error_next;
      first_capture <= first_capture_next;
      have_first    <= have_first_next;
      phase         <= phase_next;
      last_count    <= last_count_next;
    end
  end

  // Result beat from the updated state
  always_comb begin
    res.trim_out       = current_trim_next;
    res.measured_count = last_count_next;
    res.busy_res       = (phase_next != PH_IDLE);
    res.done_res       = done;
  end

  otc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (buf_ready),
    .in_data   (res),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.trim_out       = rsp_data.trim_out;
  assign rsp.measured_count = rsp_data.measured_count;
  assign rsp.busy_res       = rsp_data.busy_res;
  assign rsp.done_res       = rsp_data.done_res;

endmodule

/* sv/otc_checker.sv */
module otc_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_busy_res,
  input logic rsp_done_res,
  input logic cfg_ready
);

  // A finishing beat never reports calibration still in progress
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_done_res |-> !rsp_busy_res)
    else $error("done_res with busy_res set");

  // An empty output never holds off input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

  // A beat taken into an empty output shows up on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> rsp_valid)
    else $error("result missing one cycle after accept");

  // A waiting result stays until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // Register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind oscillator_trim_calibrator_core otc_checker u_otc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_busy_res (rsp.busy_res),
  .rsp_done_res (rsp.done_res),
  .cfg_ready    (cfg.ready)
);

/* tb/oscillator_trim_calibrator_core_tb.sv */
module oscillator_trim_calibrator_core_tb;
  import otc_pkg::*;

  localparam int CAP_W      = CAPTURE_BITS_DEF;
  localparam int MAX_GAP    = 8;
  localparam int LONG_HOLD  = 120;
  localparam int HOLD_AT    = 400;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_CYC  = 10;
  localparam int PHASE_BEATS = 80;
  localparam int MAX_REPORTS = 10;

  // Trim predictor plus queue of expected result beats
  class trim_scoreboard;
    logic [TARGET_HZ_W-1:0] target_hz;
    logic [TRIM_W-1:0]      start_trim;
    logic [TRIM_W-1:0]      cur_trim;
    logic [TRIM_W-1:0]      best_trim;
    logic [CAP_W-1:0]       best_err;
    logic [CAP_W-1:0]       first_cap;
    logic [CAP_W-1:0]       last_count;
    bit                     have_first;
    logic [PHASE_W-1:0]     phase;
    res_t                   trim_results_q[$];
    int                     mismatches;

    function new();
      target_hz  = TARGET_HZ_RST;
      start_trim = START_TRIM_RST;
      cur_trim   = '0;
      best_trim  = '0;
      best_err   = '0;
      first_cap  = '0;
      last_count = '0;
      have_first = 0;
      phase      = PH_IDLE;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TARGET_HZ) target_hz = data;
      else if (idx == REG_START_TRIM) start_trim = data[TRIM_W-1:0];
    endfunction

    function int target_count();
      return int'(target_hz >> TARGET_SHIFT);
    endfunction

    function void push_beat(bit done);
      res_t r;
      r.trim_out       = cur_trim;
      r.measured_count = last_count[MEAS_W-1:0];
      r.busy_res       = (phase != PH_IDLE);
      r.done_res       = done;
      trim_results_q.push_back(r);
    endfunction

    // Advance the hill climb by one accepted beat
    function void climb_step(logic cmd, logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] count;
      int tgt;
      int err;
      bit take;
      if (cmd == CMD_START) begin
        cur_trim   = start_trim;
        have_first = 0;
        phase      = PH_FIRST;
        push_beat(0);
        return;
      end
      if (phase == PH_IDLE) begin
        push_beat(0);
        return;
      end
      if (!have_first) begin
        first_cap  = cap;
        have_first = 1;
        push_beat(0);
        return;
      end
      have_first = 0;
      count      = cap - first_cap;
      last_count = count;
      tgt        = target_count();
      err        = (int'(count) > tgt) ? int'(count) - tgt : tgt - int'(count);
      take       = (phase == PH_FIRST) || (int'(best_err) > err);
      if (take) begin
        best_trim = cur_trim;
        if (err != 0) begin
          best_err = err[CAP_W-1:0];
          phase    = PH_NEXT;
          if (int'(count) > tgt) begin
            if (cur_trim != TRIM_MIN) cur_trim = cur_trim - 1'b1;
          end else begin
            if (cur_trim != TRIM_MAX) cur_trim = cur_trim + 1'b1;
          end
          push_beat(0);
          return;
        end
      end
      cur_trim = best_trim;
      phase    = PH_IDLE;
      push_beat(1);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_beat(res_t got);
      res_t exp_r;
      if (trim_results_q.size() == 0) begin
        flag($sformatf("unexpected result: trim %0d count %0d busy %0b done %0b",
                       got.trim_out, got.measured_count, got.busy_res, got.done_res));
        return;
      end
      exp_r = trim_results_q.pop_front();
      if (got.trim_out != exp_r.trim_out)
        flag($sformatf("trim_out: expected %0d, got %0d", exp_r.trim_out, got.trim_out));
      if (got.measured_count != exp_r.measured_count)
        flag($sformatf("measured_count: expected %0d, got %0d",
                       exp_r.measured_count, got.measured_count));
      if (got.busy_res != exp_r.busy_res)
        flag($sformatf("busy_res: expected %0b, got %0b", exp_r.busy_res, got.busy_res));
      if (got.done_res != exp_r.done_res)
        flag($sformatf("done_res: expected %0b, got %0b", exp_r.done_res, got.done_res));
    endfunction

    function int pending();
      return trim_results_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  otc_in_if #(.CAPTURE_BITS(CAP_W)) req_if();
  otc_out_if rsp_if();
  otc_cfg_if cfg_if();

  oscillator_trim_calibrator_core #(.CAPTURE_BITS(CAP_W)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  trim_scoreboard sb = new();

  bit no_idle = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  // Drive one input beat and hold it until the block takes it
  task automatic send(logic cmd, logic [CAP_W-1:0] cap);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.cmd           <= cmd;
    req_if.capture_value <= cap;
    do @(posedge clk); while (!req_if.ready);
    sb.climb_step(cmd, cap);
    beats_sent++;
  endtask

  // One measurement: two captures that differ by cnt
  task automatic measure(logic [CAP_W-1:0] first, logic [CAP_W-1:0] cnt);
    send(CMD_CAPTURE, first);
    send(CMD_CAPTURE, first + cnt);
  endtask

  // Drop valid and wait until every expected beat is back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between them
  task automatic write_regs(logic [TARGET_HZ_W-1:0] tgt_hz, logic [TRIM_W-1:0] trim0);
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    for (int i = 0; i < 2; i++) begin
      idx  = (i == 0) ? REG_TARGET_HZ : REG_START_TRIM;
      data = (i == 0) ? CFG_DATA_W'(tgt_hz) : CFG_DATA_W'(trim0);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= data;
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(idx, data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Emulate an oscillator tracking the trim, climb to the end or the step cap
  task automatic run_calibration();
    int gain;
    int ideal;
    int spread;
    int cnt;
    int steps;
    int unsigned pick;
    gain = $urandom_range(1, 40);
    if ($urandom_range(0, 7) == 0) gain = -gain;
    ideal = int'(sb.start_trim) + $urandom_range(0, 60) - 30;
    pick  = $urandom_range(0, 15);
    if (pick == 0) ideal = -10;
    else if (pick == 1) ideal = 270;
    spread = ($urandom_range(0, 3) == 0) ? (gain < 0 ? -gain : gain) : 0;
    if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
    send(CMD_START, CAP_W'($urandom_range(0, 65535)));
    steps = 0;
    while (sb.phase != PH_IDLE && steps < 60) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send(CMD_START, CAP_W'($urandom_range(0, 65535)));
      end else if (pick == 1) begin
        send(CMD_CAPTURE, CAP_W'($urandom_range(0, 65535)));
      end else begin
        cnt = sb.target_count() + gain * (int'(sb.cur_trim) - ideal);
        if (spread > 0) cnt = cnt + $urandom_range(0, 2 * spread) - spread;
        if (cnt < 0) cnt = 0;
        if (cnt > 65535) cnt = 65535;
        measure(CAP_W'($urandom_range(0, 65535)), cnt[CAP_W-1:0]);
      end
      steps++;
    end
    // Capture after the end lands on an idle block
    if ($urandom_range(0, 3) == 0) send(CMD_CAPTURE, CAP_W'($urandom_range(0, 65535)));
  endtask

  // Result side: random stalls, one long hold-off, check each beat
  initial begin
    res_t got;
    int hold;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (results_seen == HOLD_AT) hold = LONG_HOLD;
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      got.trim_out       = rsp_if.trim_out;
      got.measured_count = rsp_if.measured_count;
      got.busy_res       = rsp_if.busy_res;
      got.done_res       = rsp_if.done_res;
      sb.check_beat(got);
      results_seen++;
    end
  end

  // Watchdog: count cycles in which no channel moves a beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int start_beats;
    rst                  <= 1'b1;
    req_if.valid         <= 1'b0;
    req_if.cmd           <= CMD_START;
    req_if.capture_value <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_TARGET_HZ;
    cfg_if.data          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, target count 512, start trim 16
    send(CMD_CAPTURE, 16'hFFFF);
    send(CMD_CAPTURE, 16'h0000);
    send(CMD_START, 16'h0000);
    measure(16'hFFFF, 16'd512);
    send(CMD_START, 16'hAAAA);
    send(CMD_CAPTURE, 16'h5555);
    send(CMD_START, 16'h0000);
    measure(16'd100, 16'd600);
    measure(16'd7, 16'd550);
    measure(16'd9, 16'd550);
    send(CMD_START, 16'hFFFF);
    measure(16'h1234, 16'd0);
    measure(16'h4321, 16'd0);
    send(CMD_START, 16'h8000);
    measure(16'h0000, 16'hFFFF);
    measure(16'h0001, 16'hFFFF);
    send(CMD_CAPTURE, 16'h8000);
    drain();

    // Random phases over a range of settings, the extremes first
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_regs('0, TRIM_MIN);
        1: write_regs('1, TRIM_MAX);
        2: write_regs(TARGET_HZ_RST, 8'd128);
        default: write_regs(TARGET_HZ_W'($urandom_range(0, 67108863)),
                            TRIM_W'($urandom_range(0, 255)));
      endcase
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) run_calibration();
      drain();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/otc_pkg.sv
sv/otc_in_if.sv
sv/otc_out_if.sv
sv/otc_cfg_if.sv
sv/otc_skid.sv
sv/oscillator_trim_calibrator_core.sv
sv/otc_checker.sv
tb/oscillator_trim_calibrator_core_tb.sv
